// ----- rtl/alfs_pkg.sv -----
// Shared types, codes and helpers for the addressable LED frame sender.
`timescale 1ns / 1ps

package alfs_pkg;

  // Field widths fixed by the item format.
  localparam int unsigned ColorW = 24;
  localparam int unsigned IndexW = 8;
  localparam int unsigned TicksW = 16;
  localparam int unsigned PixCfgW = 9;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  // Item action codes.
  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_SHOW  = 2'd1,
    ACT_LATCH = 2'd2,
    ACT_TICK  = 2'd3
  } alfs_action_e;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_ZERO_HIGH = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_ZERO_LOW  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_ONE_HIGH  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_ONE_LOW   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_LATCH_LOW = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_PIXELS    = 3'd5;

  // One result transaction.
  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic rejected;
  } alfs_result_t;

  // A duration of zero counts as one tick.
  function automatic logic [TicksW-1:0] at_least_one(input logic [TicksW-1:0] v);
    at_least_one = (v == '0) ? TicksW'(1) : v;
  endfunction

endpackage

// ----- rtl/addressable_led_frame_sender_unit.sv -----
// Top level of the addressable LED frame sender: bit sequencer, registers and glue.
// The result of an accepted item is registered and offered behind any older results.
// One item per cycle while in_ready_o is high; the sequencer updates in the accepting cycle.
// Up to two results are buffered, so input keeps flowing while a result waits.
// Reset: asynchronous, active low; afterwards a clearing pass zeroes the whole frame store,
// with in_ready_o low; configuration writes are taken throughout.
`timescale 1ns / 1ps

module addressable_led_frame_sender_unit #(
  parameter int unsigned PIXELS = 256,
  parameter int unsigned BITS_PER_PIXEL = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    action_i,
  input  logic [alfs_pkg::IndexW-1:0]   pixel_index_i,
  input  logic [alfs_pkg::ColorW-1:0]   pixel_color_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          line_level_o,
  output logic                          busy_res_o,
  output logic                          rejected_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [alfs_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [alfs_pkg::CfgDataW-1:0] cfg_data_i
);
  import alfs_pkg::*;

  localparam int unsigned AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int unsigned BW = $clog2(BITS_PER_PIXEL);
  localparam int unsigned CW = ($clog2(PIXELS + 1) > PixCfgW) ? $clog2(PIXELS + 1) : PixCfgW;
  localparam logic [BW-1:0] BitTop = BW'(BITS_PER_PIXEL - 1);
  localparam logic [CW-1:0] PixMax = CW'(PIXELS);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_FRAME,
    MODE_LATCH
  } mode_e;

  // Configuration registers.
  logic [TicksW-1:0]  zero_high_q, zero_low_q, one_high_q, one_low_q, latch_low_q;
  logic [PixCfgW-1:0] pix_use_q;

  // Sequencer state.
  mode_e             mode_q, mode_d;
  logic [AW-1:0]     ptr_q, ptr_d;
  logic [BW-1:0]     bitp_q, bitp_d;
  logic              phase_q, phase_d;
  logic [TicksW-1:0] timer_q, timer_d;
  logic [ColorW-1:0] word_q, word_d;
  logic              line_q, line_d;
  logic [ColorW-1:0] pix0_q, pix0_d;

  logic              in_fire, busy, clearing, buf_full, rej;
  logic              mem_we, next_in_range, idx_ok, cur_bit;
  logic [AW-1:0]     ptr_next;
  logic [ColorW-1:0] rd_data;
  logic [CW-1:0]     pix_cnt, pix_sat;
  logic [TicksW-1:0] tmr_dec;
  alfs_action_e      act;
  alfs_result_t      res, out_res;

  // Bit of a pixel word; bit positions above the color width send zero.
  function automatic logic bit_of(input logic [ColorW-1:0] w, input logic [BW-1:0] bp);
    bit_of = (32'(bp) < ColorW) ? w[bp] : 1'b0;
  endfunction

  // Configuration write transaction; unknown indexes are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_high_q <= TicksW'(1);
      zero_low_q  <= TicksW'(2);
      one_high_q  <= TicksW'(2);
      one_low_q   <= TicksW'(1);
      latch_low_q <= TicksW'(114);
      pix_use_q   <= PixCfgW'(256);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ZERO_HIGH: zero_high_q <= cfg_data_i;
        CFG_ZERO_LOW:  zero_low_q  <= cfg_data_i;
        CFG_ONE_HIGH:  one_high_q  <= cfg_data_i;
        CFG_ONE_LOW:   one_low_q   <= cfg_data_i;
        CFG_LATCH_LOW: latch_low_q <= cfg_data_i;
        CFG_PIXELS:    pix_use_q   <= cfg_data_i[PixCfgW-1:0];
        default: ;
      endcase
    end
  end

  // Effective pixel count, clamped to one and to the store depth.
  always_comb begin
    pix_sat = (pix_use_q == '0) ? CW'(1) : CW'(pix_use_q);
    pix_cnt = (pix_sat > PixMax) ? PixMax : pix_sat;
  end

  assign in_ready_o = !clearing && !buf_full;
  assign in_fire    = in_valid_i && in_ready_o;
  assign act        = alfs_action_e'(action_i);
  assign busy       = (mode_q != MODE_IDLE);
  assign cur_bit    = bit_of(word_q, bitp_q);
  assign ptr_next   = (ptr_q == AW'(PIXELS - 1)) ? '0 : ptr_q + AW'(1);
  assign next_in_range = (CW'(ptr_q) + CW'(1)) < pix_cnt;
  assign idx_ok     = CW'(pixel_index_i) < pix_cnt;
  assign tmr_dec    = (timer_q != '0) ? timer_q - TicksW'(1) : '0;

  // Sequencer: one transaction updates the line state in a single pass.
  always_comb begin
    mode_d  = mode_q;
    ptr_d   = ptr_q;
    bitp_d  = bitp_q;
    phase_d = phase_q;
    timer_d = timer_q;
    word_d  = word_q;
    line_d  = line_q;
    pix0_d  = pix0_q;
    rej     = 1'b0;
    mem_we  = 1'b0;
    if (in_fire) begin
      if (act == ACT_TICK) begin
        if (busy) begin
          timer_d = tmr_dec;
          if (tmr_dec == '0) begin
            if (mode_q == MODE_LATCH) begin
              mode_d = MODE_IDLE;
              line_d = 1'b0;
            end else if (!phase_q) begin
              // High phase over: start the low phase of the same bit.
              phase_d = 1'b1;
              timer_d = at_least_one(cur_bit ? one_low_q : zero_low_q);
              line_d  = 1'b0;
            end else if (bitp_q != '0) begin
              // Next bit of the current pixel.
              bitp_d  = bitp_q - BW'(1);
              phase_d = 1'b0;
              timer_d = at_least_one(bit_of(word_q, bitp_q - BW'(1)) ?
                                     one_high_q : zero_high_q);
              line_d  = 1'b1;
            end else if (next_in_range) begin
              // Next pixel comes from the prefetched read data.
              ptr_d   = ptr_next;
              word_d  = rd_data;
              bitp_d  = BitTop;
              phase_d = 1'b0;
              timer_d = at_least_one(bit_of(rd_data, BitTop) ? one_high_q : zero_high_q);
              line_d  = 1'b1;
            end else begin
              mode_d  = MODE_IDLE;
              phase_d = 1'b0;
              line_d  = 1'b0;
            end
          end
        end
      end else if (busy) begin
        rej = 1'b1;
      end else if (act == ACT_WRITE) begin
        if (idx_ok) begin
          mem_we = 1'b1;
          if (pixel_index_i == '0) begin
            pix0_d = pixel_color_i;
          end
        end else begin
          rej = 1'b1;
        end
      end else if (act == ACT_SHOW) begin
        mode_d  = MODE_FRAME;
        ptr_d   = '0;
        word_d  = pix0_q;
        bitp_d  = BitTop;
        phase_d = 1'b0;
        timer_d = at_least_one(bit_of(pix0_q, BitTop) ? one_high_q : zero_high_q);
        line_d  = 1'b1;
      end else begin
        mode_d  = MODE_LATCH;
        phase_d = 1'b0;
        timer_d = at_least_one(latch_low_q);
        line_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      ptr_q   <= '0;
      bitp_q  <= '0;
      phase_q <= 1'b0;
      timer_q <= '0;
      word_q  <= '0;
      line_q  <= 1'b0;
      pix0_q  <= '0;
    end else begin
      mode_q  <= mode_d;
      ptr_q   <= ptr_d;
      bitp_q  <= bitp_d;
      phase_q <= phase_d;
      timer_q <= timer_d;
      word_q  <= word_d;
      line_q  <= line_d;
      pix0_q  <= pix0_d;
    end
  end

  // Frame store; the read port always prefetches the pixel after the current one.
  alfs_frame_store #(
    .PIXELS (PIXELS),
    .AW     (AW)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (mem_we),
    .wr_addr_i  (AW'(pixel_index_i)),
    .wr_data_i  (pixel_color_i),
    .rd_addr_i  (ptr_next),
    .rd_data_o  (rd_data),
    .clearing_o (clearing)
  );

  // Result of each transaction, as the state stands after it.
  always_comb begin
    res.line_level = line_d;
    res.busy_res   = (mode_d != MODE_IDLE);
    res.rejected   = rej;
  end

  alfs_out_buffer u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_fire),
    .push_data_i (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_res)
  );

  assign line_level_o = out_res.line_level;
  assign busy_res_o   = out_res.busy_res;
  assign rejected_o   = out_res.rejected;

  // The line is low whenever no frame is being sent.
  a_line_low_unless_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q != MODE_FRAME) |-> !line_q)
    else $error("line high outside a frame");

  // A running phase always has time left on its timer.
  a_timer_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q != MODE_IDLE) |-> (timer_q != '0))
    else $error("busy with an expired phase timer");

  // A command taken while busy leaves the sequencer untouched.
  a_busy_cmd_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && busy && (act != ACT_TICK)) |=>
      ($stable(timer_q) && $stable(mode_q) && $stable(ptr_q)))
    else $error("busy command changed sequencer state");

  // No item is taken while the clearing pass runs.
  a_no_item_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !in_fire && !mem_we)
    else $error("item accepted during clearing pass");

endmodule

// ----- rtl/alfs_frame_store.sv -----
// Pixel color memory with one write port, one registered read port and a clearing pass.
`timescale 1ns / 1ps

module alfs_frame_store #(
  parameter int unsigned PIXELS = 256,
  parameter int unsigned AW = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       wr_en_i,
  input  logic [AW-1:0]              wr_addr_i,
  input  logic [alfs_pkg::ColorW-1:0] wr_data_i,
  input  logic [AW-1:0]              rd_addr_i,
  output logic [alfs_pkg::ColorW-1:0] rd_data_o,
  output logic                       clearing_o
);
  import alfs_pkg::*;

  logic [ColorW-1:0] mem [PIXELS];
  logic [ColorW-1:0] rd_data_q;
  logic              clearing_q, clearing_d;
  logic [AW-1:0]     clr_addr_q, clr_addr_d;
  logic              mem_we;
  logic [AW-1:0]     mem_addr;
  logic [ColorW-1:0] mem_data;

  // Clearing pass sweeps every entry once after reset.
  always_comb begin
    clearing_d = clearing_q;
    clr_addr_d = clr_addr_q;
    if (clearing_q) begin
      if (clr_addr_q == AW'(PIXELS - 1)) begin
        clearing_d = 1'b0;
      end else begin
        clr_addr_d = clr_addr_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clearing_q <= clearing_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  // The write port serves the clearing pass first, then pixel writes.
  always_comb begin
    mem_we   = clearing_q | wr_en_i;
    mem_addr = clearing_q ? clr_addr_q : wr_addr_i;
    mem_data = clearing_q ? '0 : wr_data_i;
  end

  // Memory array with registered read data.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_data;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o  = rd_data_q;
  assign clearing_o = clearing_q;

endmodule

// ----- rtl/alfs_out_buffer.sv -----
// Two-entry result buffer that decouples the result channel from the input channel.
`timescale 1ns / 1ps

module alfs_out_buffer (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  alfs_pkg::alfs_result_t push_data_i,
  output logic                   full_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output alfs_pkg::alfs_result_t out_data_o
);
  import alfs_pkg::*;

  alfs_result_t ent_q [2];
  alfs_result_t ent_d [2];
  logic [1:0]   cnt_q, cnt_d;
  logic         pop;

  assign pop = out_valid_o & out_ready_i;

  // Pop shifts the tail forward; push lands behind whatever remains.
  always_comb begin
    ent_d[0] = ent_q[0];
    ent_d[1] = ent_q[1];
    cnt_d    = cnt_q;
    if (pop) begin
      ent_d[0] = ent_q[1];
      cnt_d    = cnt_q - 2'd1;
    end
    if (push_i) begin
      ent_d[cnt_d[0]] = push_data_i;
      cnt_d           = cnt_d + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q[0] <= ent_d[0];
    ent_q[1] <= ent_d[1];
  end

  assign full_o      = (cnt_q == 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = ent_q[0];

endmodule

// ----- sim/tb_alfs_sb_pkg.sv -----
// Scoreboard class that predicts and checks the results of the LED frame sender.
`timescale 1ns / 1ps

package tb_alfs_sb_pkg;
  import alfs_pkg::*;

  // Sequencer modes of the predictor.
  typedef enum logic [1:0] {
    SendIdle  = 2'd0,
    SendFrame = 2'd1,
    SendLatch = 2'd2
  } send_mode_e;

  localparam int unsigned StoreDepth = 256;
  localparam int unsigned PixelBits = 24;

  class led_frame_scoreboard;
    logic [ColorW-1:0]  pixel_mem [StoreDepth];
    send_mode_e         mode;
    logic [IndexW-1:0]  pix_ptr;
    logic [4:0]         bit_ptr;
    logic               low_phase;
    logic [TicksW-1:0]  timer;
    logic [ColorW-1:0]  word;
    logic               line;
    logic [TicksW-1:0]  zero_high, zero_low, one_high, one_low, latch_low;
    logic [PixCfgW-1:0] pix_cfg;
    alfs_result_t       pending_results [$];
    int unsigned        errors;

    // State and registers as they stand after reset.
    function new();
      foreach (pixel_mem[i]) pixel_mem[i] = '0;
      mode      = SendIdle;
      pix_ptr   = '0;
      bit_ptr   = '0;
      low_phase = 1'b0;
      timer     = '0;
      word      = '0;
      line      = 1'b0;
      zero_high = 16'd1;
      zero_low  = 16'd2;
      one_high  = 16'd2;
      one_low   = 16'd1;
      latch_low = 16'd114;
      pix_cfg   = 9'd256;
      errors    = 0;
    endfunction

    // A programmed duration of zero lasts one tick.
    function logic [TicksW-1:0] ticks_or_one(logic [TicksW-1:0] v);
      return (v == '0) ? 16'd1 : v;
    endfunction

    // Pixel count in use, clamped to one and to the store size.
    function int unsigned frame_pixels();
      int unsigned n;
      n = (pix_cfg == '0) ? 1 : pix_cfg;
      return (n > StoreDepth) ? StoreDepth : n;
    endfunction

    function bit busy();
      return mode != SendIdle;
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    function void begin_high();
      low_phase = 1'b0;
      timer = ticks_or_one(word[bit_ptr] ? one_high : zero_high);
      line = 1'b1;
    endfunction

    function void load_pixel(int unsigned p);
      pix_ptr = IndexW'(p);
      word = pixel_mem[p % StoreDepth];
      bit_ptr = 5'(PixelBits - 1);
      begin_high();
    endfunction

    // Move on to the next phase once the current one has run out.
    function void advance_phase();
      int unsigned next_pix;
      next_pix = pix_ptr;
      next_pix++;
      if (mode == SendLatch) begin
        mode = SendIdle;
        line = 1'b0;
      end else if (!low_phase) begin
        low_phase = 1'b1;
        timer = ticks_or_one(word[bit_ptr] ? one_low : zero_low);
        line = 1'b0;
      end else if (bit_ptr > 0) begin
        bit_ptr--;
        begin_high();
      end else if (next_pix < frame_pixels()) begin
        load_pixel(next_pix);
      end else begin
        mode = SendIdle;
        low_phase = 1'b0;
        line = 1'b0;
      end
    endfunction

    // Apply one register write.
    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_ZERO_HIGH: zero_high = data;
        CFG_ZERO_LOW:  zero_low = data;
        CFG_ONE_HIGH:  one_high = data;
        CFG_ONE_LOW:   one_low = data;
        CFG_LATCH_LOW: latch_low = data;
        CFG_PIXELS:    pix_cfg = data[PixCfgW-1:0];
        default: ;
      endcase
    endfunction

    // Predict the result of an accepted item; returns 1 if the item had an effect.
    function bit predict_item(alfs_action_e act, logic [IndexW-1:0] idx,
                              logic [ColorW-1:0] color);
      alfs_result_t res;
      bit was_busy;
      was_busy = busy();
      res.rejected = 1'b0;
      if (act == ACT_TICK) begin
        if (was_busy) begin
          if (timer != '0) timer--;
          if (timer == '0) advance_phase();
        end
      end else if (was_busy) begin
        res.rejected = 1'b1;
      end else if (act == ACT_WRITE) begin
        if (int'(idx) < frame_pixels()) pixel_mem[idx] = color;
        else res.rejected = 1'b1;
      end else if (act == ACT_SHOW) begin
        mode = SendFrame;
        load_pixel(0);
      end else begin
        mode = SendLatch;
        low_phase = 1'b0;
        timer = ticks_or_one(latch_low);
        line = 1'b0;
      end
      res.line_level = line;
      res.busy_res = busy();
      pending_results.push_back(res);
      return !res.rejected && (act != ACT_TICK || was_busy);
    endfunction

    // Compare one accepted result with the oldest prediction.
    function void check_result(logic line_lvl, logic busy_lvl, logic rej);
      alfs_result_t exp_res;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: line %0b busy %0b rejected %0b",
                 $time, line_lvl, busy_lvl, rej);
        return;
      end
      exp_res = pending_results.pop_front();
      if (exp_res.line_level !== line_lvl) begin
        errors++;
        $display("%0t: line_level expected %0b, actual %0b", $time, exp_res.line_level, line_lvl);
      end
      if (exp_res.busy_res !== busy_lvl) begin
        errors++;
        $display("%0t: busy_res expected %0b, actual %0b", $time, exp_res.busy_res, busy_lvl);
      end
      if (exp_res.rejected !== rej) begin
        errors++;
        $display("%0t: rejected expected %0b, actual %0b", $time, exp_res.rejected, rej);
      end
    endfunction
  endclass

endpackage

// ----- sim/tb_top.sv -----
// Top-level testbench of the addressable LED frame sender with stimulus and checking.
`timescale 1ns / 1ps

module tb_top;
  import alfs_pkg::*;
  import tb_alfs_sb_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = 3'd7;
  localparam int unsigned ResetCycles = 11;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned RandomPhases = 4;
  localparam int unsigned ItemsPerPhase = 50;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [1:0]          action_i;
  logic [IndexW-1:0]   pixel_index_i;
  logic [ColorW-1:0]   pixel_color_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic                line_level_o;
  logic                busy_res_o;
  logic                rejected_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  led_frame_scoreboard sb;
  bit gaps_on = 1'b1;
  bit hold_req = 1'b0;
  bit took;

  addressable_led_frame_sender_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .pixel_index_i(pixel_index_i),
    .pixel_color_i(pixel_color_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .line_level_o (line_level_o),
    .busy_res_o   (busy_res_o),
    .rejected_o   (rejected_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // Clock with a 12 ns period.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // The slowest correct run stays well below this bound.
  initial begin
    #48_000_000;
    $display("tb_top: errors");
    $finish;
  end

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin
    int burst;
    burst = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
        out_ready_i <= 1'b1;
      end else if (burst > 0) begin
        burst--;
        out_ready_i <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(0, 3);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Every accepted result transaction is checked against the prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result(line_level_o, busy_res_o, rejected_o);
    end
  end

  // Offer one item and hold it until the transaction completes.
  task automatic send_item(alfs_action_e act, logic [IndexW-1:0] idx,
                           logic [ColorW-1:0] color, output bit counted);
    @(negedge clk_i);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    pixel_index_i <= idx;
    pixel_color_i <= color;
    do @(posedge clk_i); while (!in_ready_o);
    counted = sb.predict_item(act, idx, color);
  endtask

  // Stop offering items and wait until every predicted result has arrived.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Tick until the current frame or latch is over, then drain.
  task automatic settle();
    bit c;
    while (sb.busy()) send_item(ACT_TICK, 8'($urandom), 24'($urandom), c);
    wait_drained();
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // One random item, mostly ticks while a frame is on the line.
  task automatic random_item(output bit counted);
    int unsigned pick;
    logic [IndexW-1:0] idx;
    pick = $urandom_range(0, 99);
    idx = 8'($urandom);
    if (sb.busy()) begin
      if (pick < 92) send_item(ACT_TICK, idx, 24'($urandom), counted);
      else send_item(alfs_action_e'($urandom_range(0, 2)), idx, 24'($urandom), counted);
    end else if (pick < 50) begin
      if ($urandom_range(0, 9) < 7) idx = 8'($urandom_range(0, sb.frame_pixels() - 1));
      send_item(ACT_WRITE, idx, 24'($urandom), counted);
    end else if (pick < 70) begin
      send_item(ACT_SHOW, idx, 24'($urandom), counted);
    end else if (pick < 82) begin
      send_item(ACT_LATCH, idx, 24'($urandom), counted);
    end else begin
      send_item(ACT_TICK, idx, 24'($urandom), counted);
    end
  endtask

  // Main sequence: reset, directed cases, then random phases.
  initial begin
    int unsigned done_items;
    sb = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    action_i = ACT_TICK;
    pixel_index_i = '0;
    pixel_color_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_ZERO_HIGH;
    cfg_data_i = '0;
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: idle tick and writes at both ends, then a short two-pixel frame.
    send_item(ACT_TICK, 8'd0, 24'd0, took);
    send_item(ACT_WRITE, 8'd0, 24'hFFFFFF, took);
    send_item(ACT_WRITE, 8'd255, 24'h800000, took);
    send_item(ACT_WRITE, 8'd1, 24'h000000, took);
    wait_drained();
    write_reg(CFG_PIXELS, 16'd2);
    send_item(ACT_SHOW, 8'd0, 24'd0, took);
    // Commands while busy are refused.
    send_item(ACT_WRITE, 8'd2, 24'h123456, took);
    send_item(ACT_SHOW, 8'd0, 24'd0, took);
    send_item(ACT_LATCH, 8'd0, 24'd0, took);
    settle();
    send_item(ACT_LATCH, 8'd0, 24'd0, took);
    settle();

    // One pixel with a long one bit; zero durations act as one tick.
    gaps_on = 1'b0;
    write_reg(CFG_PIXELS, 16'hFE01);
    write_reg(CFG_ZERO_HIGH, 16'h0000);
    write_reg(CFG_ZERO_LOW, 16'h0000);
    write_reg(CFG_ONE_HIGH, 16'h0008);
    write_reg(CFG_ONE_LOW, 16'h0008);
    send_item(ACT_WRITE, 8'd0, 24'h800000, took);
    send_item(ACT_WRITE, 8'd1, 24'hFFFFFF, took);
    send_item(ACT_WRITE, 8'd255, 24'hFFFFFF, took);
    send_item(ACT_SHOW, 8'd0, 24'd0, took);
    settle();

    // A long zero bit and a long latch.
    write_reg(CFG_ZERO_HIGH, 16'h0008);
    write_reg(CFG_ZERO_LOW, 16'h0008);
    write_reg(CFG_ONE_HIGH, 16'h0000);
    write_reg(CFG_ONE_LOW, 16'h0000);
    write_reg(CFG_LATCH_LOW, 16'h0020);
    send_item(ACT_WRITE, 8'd0, 24'h7FFFFF, took);
    send_item(ACT_SHOW, 8'd0, 24'd0, took);
    settle();
    send_item(ACT_LATCH, 8'd0, 24'd0, took);
    settle();
    gaps_on = 1'b1;

    // Pixel count clamping, a zero latch length and unused register indexes.
    write_reg(CFG_PIXELS, 16'h01FF);
    write_reg(CFG_LATCH_LOW, 16'h0000);
    write_reg(CFG_ZERO_HIGH, 16'h0001);
    write_reg(CFG_ZERO_LOW, 16'h0001);
    write_reg(CFG_ONE_HIGH, 16'h0001);
    write_reg(CFG_ONE_LOW, 16'h0001);
    write_reg(CfgSpareLo, 16'hFFFF);
    write_reg(CfgSpareHi, 16'hFFFF);
    send_item(ACT_WRITE, 8'd255, 24'hC3C3C3, took);
    wait_drained();
    write_reg(CFG_PIXELS, 16'h0000);
    send_item(ACT_WRITE, 8'd0, 24'h5A5A5A, took);
    send_item(ACT_WRITE, 8'd1, 24'h5A5A5A, took);
    send_item(ACT_SHOW, 8'd0, 24'd0, took);
    settle();
    send_item(ACT_LATCH, 8'd0, 24'd0, took);
    settle();

    // Random phases with short timings; the last one runs without idling.
    for (int ph = 0; ph < RandomPhases; ph++) begin
      if (ph == RandomPhases - 1) gaps_on = 1'b0;
      write_reg(CFG_ZERO_HIGH, 16'($urandom_range(0, 3)));
      write_reg(CFG_ZERO_LOW, 16'($urandom_range(0, 3)));
      write_reg(CFG_ONE_HIGH, 16'($urandom_range(0, 3)));
      write_reg(CFG_ONE_LOW, 16'($urandom_range(0, 3)));
      write_reg(CFG_LATCH_LOW, 16'($urandom_range(0, 24)));
      write_reg(CFG_PIXELS, {7'($urandom), 9'($urandom_range(0, 2))});
      write_reg($urandom_range(0, 1) ? CfgSpareHi : CfgSpareLo, 16'($urandom));
      // The result side holds off while writes keep coming, filling the block.
      if (ph == 1) begin
        hold_req = 1'b1;
        for (int k = 0; k < 40; k++) begin
          send_item(ACT_WRITE, 8'($urandom_range(0, sb.frame_pixels() - 1)),
                    24'($urandom), took);
        end
      end
      done_items = 0;
      while (done_items < ItemsPerPhase) begin
        random_item(took);
        if (took) done_items++;
      end
      settle();
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/alfs_pkg.sv
rtl/alfs_frame_store.sv
rtl/alfs_out_buffer.sv
rtl/addressable_led_frame_sender_unit.sv
sim/tb_alfs_sb_pkg.sv
sim/tb_top.sv
